// File: sv/xml_entity_unescape_utf8_defines.svh
// assertion helpers shared by the decoder modules
`ifndef XML_ENTITY_UNESCAPE_UTF8_DEFINES_SVH
`define XML_ENTITY_UNESCAPE_UTF8_DEFINES_SVH

// condition holds at every clock edge out of reset
`define XEU_ASSERT(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// consequent holds in the same cycle as the antecedent
`define XEU_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent holds in the cycle after the antecedent
`define XEU_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: sv/xeu_pkg.sv
`timescale 1ns / 1ps

package xeu_pkg;

    localparam int NUM_ENT        = 5;
    // longest named body before its ';' ("quot", "apos")
    localparam int MAX_NAMED_PEND = 4;

    localparam logic [7:0]  CH_AMP  = 8'h26;
    localparam logic [7:0]  CH_HASH = 8'h23;
    localparam logic [7:0]  CH_SEMI = 8'h3B;
    localparam logic [7:0]  CH_X_LO = 8'h78;
    localparam logic [7:0]  CH_X_UP = 8'h58;
    localparam logic [20:0] CP_MAX  = 21'h10FFFF;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       in_last;
    } t_in_beat;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       run_last;
        logic       string_end;
    } t_out_beat;

    typedef enum logic [2:0] {
        MODE_IDLE  = 3'd0,
        MODE_NAMED = 3'd1,
        MODE_HASH  = 3'd2,
        MODE_DEC   = 3'd3,
        MODE_HEX   = 3'd4
    } t_mode;

    typedef enum logic [2:0] {
        ST_IN,
        ST_EVAL,
        ST_AMP,
        ST_FBYTE,
        ST_UTF
    } t_state;

    typedef enum logic [2:0] {
        ACT_EMIT_C,
        ACT_OPEN,
        ACT_ENT,
        ACT_PUSH,
        ACT_DIGIT,
        ACT_UTF,
        ACT_FLUSH
    } t_act;

    typedef struct packed {
        logic       clr;
        logic       step;
        logic       hex;
        logic [3:0] digit;
    } t_acc_cmd;

    typedef struct packed {
        logic [20:0] value;
        logic        ovf;
        logic        has_digits;
    } t_acc_stat;

    // byte n of the body of named entity e (lt gt amp quot apos)
    function automatic logic [7:0] ent_body_byte(input logic [2:0] e, input logic [2:0] n);
        logic [7:0] b;
        begin
            unique case ({e, n})
                {3'd0, 3'd0}: b = "l";
                {3'd0, 3'd1}: b = "t";
                {3'd0, 3'd2}: b = ";";
                {3'd1, 3'd0}: b = "g";
                {3'd1, 3'd1}: b = "t";
                {3'd1, 3'd2}: b = ";";
                {3'd2, 3'd0}: b = "a";
                {3'd2, 3'd1}: b = "m";
                {3'd2, 3'd2}: b = "p";
                {3'd2, 3'd3}: b = ";";
                {3'd3, 3'd0}: b = "q";
                {3'd3, 3'd1}: b = "u";
                {3'd3, 3'd2}: b = "o";
                {3'd3, 3'd3}: b = "t";
                {3'd3, 3'd4}: b = ";";
                {3'd4, 3'd0}: b = "a";
                {3'd4, 3'd1}: b = "p";
                {3'd4, 3'd2}: b = "o";
                {3'd4, 3'd3}: b = "s";
                {3'd4, 3'd4}: b = ";";
                default:      b = 8'h00;
            endcase
            return b;
        end
    endfunction

    function automatic logic [2:0] ent_len(input logic [2:0] e);
        logic [2:0] l;
        begin
            unique case (e)
                3'd0, 3'd1: l = 3'd3;
                3'd2:       l = 3'd4;
                3'd3, 3'd4: l = 3'd5;
                default:    l = 3'd0;
            endcase
            return l;
        end
    endfunction

    function automatic logic [7:0] ent_char(input logic [2:0] e);
        logic [7:0] ch;
        begin
            unique case (e)
                3'd0:    ch = 8'h3C;
                3'd1:    ch = 8'h3E;
                3'd2:    ch = 8'h26;
                3'd3:    ch = 8'h22;
                3'd4:    ch = 8'h27;
                default: ch = 8'h00;
            endcase
            return ch;
        end
    endfunction

    // {valid, value}; letters only count in hex mode
    function automatic logic [4:0] digit_val(input logic [7:0] c, input logic hex);
        logic [4:0] r;
        begin
            if (c >= 8'h30 && c <= 8'h39) begin
                r = {1'b1, c[3:0]};
            end else if (hex && ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46))) begin
                r = {1'b1, c[3:0] + 4'd9};
            end else begin
                r = 5'd0;
            end
            return r;
        end
    endfunction

    // index of the final utf-8 byte (0 to 3)
    function automatic logic [1:0] utf8_top(input logic [20:0] cp);
        logic [1:0] t;
        begin
            if (cp <= 21'h00007F) begin
                t = 2'd0;
            end else if (cp <= 21'h0007FF) begin
                t = 2'd1;
            end else if (cp <= 21'h00FFFF) begin
                t = 2'd2;
            end else begin
                t = 2'd3;
            end
            return t;
        end
    endfunction

    function automatic logic [7:0] utf8_byte(input logic [20:0] cp, input logic [1:0] top,
                                             input logic [1:0] j);
        logic [7:0] b;
        logic [1:0] grp;
        begin
            grp = top - j;
            if (j == 2'd0) begin
                unique case (top)
                    2'd0: b = cp[7:0];
                    2'd1: b = {3'b110, cp[10:6]};
                    2'd2: b = {4'b1110, cp[15:12]};
                    2'd3: b = {5'b11110, cp[20:18]};
                endcase
            end else begin
                unique case (grp)
                    2'd1:    b = {2'b10, cp[11:6]};
                    2'd2:    b = {2'b10, cp[17:12]};
                    default: b = {2'b10, cp[5:0]};
                endcase
            end
            return b;
        end
    endfunction

endpackage

// File: sv/xeu_ram.sv
`timescale 1ns / 1ps

module xeu_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read data holds while no read is issued
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: sv/xeu_acc.sv
`timescale 1ns / 1ps
`include "xml_entity_unescape_utf8_defines.svh"

module xeu_acc import xeu_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_acc_cmd  i_cmd,
    output t_acc_stat o_stat
);

    logic [20:0] r_value, n_value;
    logic        r_ovf, n_ovf;
    logic [4:0]  r_dcount, n_dcount;
    logic [24:0] w_scaled;
    logic [24:0] w_sum;

    // value * base + digit, base 10 as two shifts
    always_comb begin
        if (i_cmd.hex) begin
            w_scaled = {r_value, 4'b0000};
        end else begin
            w_scaled = {1'b0, r_value, 3'b000} + {3'b000, r_value, 1'b0};
        end
        w_sum = w_scaled + {21'd0, i_cmd.digit};
    end

    always_comb begin
        n_value  = r_value;
        n_ovf    = r_ovf;
        n_dcount = r_dcount;
        if (i_cmd.clr) begin
            n_value  = '0;
            n_ovf    = 1'b0;
            n_dcount = '0;
        end else if (i_cmd.step) begin
            if (r_dcount != 5'd31) begin
                n_dcount = r_dcount + 5'd1;
            end
            if (!r_ovf) begin
                if (w_sum > {4'd0, CP_MAX}) begin
                    n_ovf = 1'b1;
                end else begin
                    n_value = w_sum[20:0];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_value  <= '0;
            r_ovf    <= 1'b0;
            r_dcount <= '0;
        end else begin
            r_value  <= n_value;
            r_ovf    <= n_ovf;
            r_dcount <= n_dcount;
        end
    end

    assign o_stat = '{value: r_value, ovf: r_ovf, has_digits: (r_dcount != 5'd0)};

    `XEU_ASSERT(a_cp_range, i_clk, i_rst_n, r_value <= CP_MAX, "value beyond code point range")
    `XEU_ASSERT_NXT(a_ovf_hold, i_clk, i_rst_n, r_ovf && !i_cmd.clr, $stable(r_value), "value moved after overflow")
    `XEU_ASSERT_NXT(a_count_up, i_clk, i_rst_n, i_cmd.step && !i_cmd.clr, r_dcount != 5'd0, "digit step left no count")

endmodule

// File: sv/xml_entity_unescape_utf8.sv
`timescale 1ns / 1ps
`include "xml_entity_unescape_utf8_defines.svh"

// xml character reference decoder, escaped bytes in, utf-8 bytes out
// input channel: one escaped byte a beat plus in_last on the final byte of a string
// output channel: one decoded byte a beat; run_last marks the last byte caused by an
// input beat, string_end the last byte of the string
// an input beat may cause no output (bytes of an open reference are held back)
// sequence: an ordinary byte is accepted in ST_IN and emitted from ST_EVAL into the
// output register; a closed numeric reference emits its utf-8 bytes from ST_UTF, a
// named entity its character from ST_EVAL; a failed reference emits '&' from ST_AMP
// and its pending bytes from ST_FBYTE through the pending buffer's single read port,
// one byte a cycle unless the output stalls, then the breaking byte is handled again
// the accumulator (value * base + digit) is one shared unit stepped once per digit
// the input is not ready while an item is being worked on
// a stalled receiver holds the output register and the sequencer waits on it
// reset (i_rst_n low, synchronous) closes any open reference and empties the output;
// no clearing pass is needed

module xml_entity_unescape_utf8 import xeu_pkg::*; #(
    parameter int PENDING_MAX = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_beat  i_in_beat,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_beat o_out_beat
);

    localparam int PC_W = $clog2(PENDING_MAX + 1);
    localparam int AW   = $clog2(PENDING_MAX);

    t_state               r_state, n_state;
    t_mode                r_mode, n_mode;
    logic [PC_W-1:0]      r_count, n_count;
    logic [NUM_ENT-1:0]   r_cand, n_cand;
    logic [AW-1:0]        r_k, n_k;
    logic                 r_end, n_end;
    logic [7:0]           r_byte, n_byte;
    logic                 r_last, n_last;
    logic                 r_ovalid;
    t_out_beat            r_obeat;

    logic                 w_ofree;
    t_act                 w_act;
    t_mode                w_push_mode;
    logic [NUM_ENT-1:0]   w_push_cand;
    logic [NUM_ENT-1:0]   w_match;
    logic                 w_any_done;
    logic [2:0]           w_done_e;
    logic [4:0]           w_dig;
    logic                 w_full;
    logic                 w_fin_cond;
    logic                 w_last_idx;
    logic [1:0]           w_utop;
    logic                 w_utf_last;
    logic                 w_emit;
    logic [7:0]           w_obyte;
    logic                 w_final;
    logic                 w_we;
    logic                 w_re;
    logic [AW-1:0]        w_raddr;
    logic [7:0]           w_rdata;
    t_acc_cmd             w_cmd;
    t_acc_stat            w_stat;

    xeu_acc u_acc (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_cmd),
        .o_stat  (w_stat)
    );

    xeu_ram #(
        .WIDTH (8),
        .DEPTH (PENDING_MAX)
    ) u_pend (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_count[AW-1:0]),
        .i_wdata (r_byte),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    assign w_ofree    = !r_ovalid || i_out_ready;
    assign w_dig      = digit_val(r_byte, r_mode == MODE_HEX);
    assign w_full     = r_count >= PC_W'(PENDING_MAX);
    // last flushed byte ends the run unless the breaking byte still has output to give
    assign w_fin_cond = r_end || (r_byte == CH_AMP && !r_last);
    assign w_last_idx = (PC_W'(r_k) + PC_W'(1)) == r_count;
    assign w_utop     = utf8_top(w_stat.value);
    assign w_utf_last = r_k[1:0] == w_utop;

    // named entity candidates still matching the pending prefix
    always_comb begin
        w_match    = '0;
        w_any_done = 1'b0;
        w_done_e   = '0;
        for (int e = NUM_ENT - 1; e >= 0; e--) begin
            w_match[e] = r_cand[e] && (r_count < PC_W'(ent_len(3'(e))))
                         && (ent_body_byte(3'(e), r_count[2:0]) == r_byte);
            if (w_match[e] && ((r_count + PC_W'(1)) == PC_W'(ent_len(3'(e))))) begin
                w_any_done = 1'b1;
                w_done_e   = 3'(e);
            end
        end
    end

    // what the held byte does in the current parse mode
    always_comb begin
        w_act       = ACT_FLUSH;
        w_push_mode = r_mode;
        w_push_cand = r_cand;
        unique case (r_mode)
            MODE_NAMED: begin
                if (r_count == '0 && r_byte == CH_HASH) begin
                    w_act       = ACT_PUSH;
                    w_push_mode = MODE_HASH;
                end else if (w_any_done) begin
                    w_act = ACT_ENT;
                end else if (|w_match) begin
                    w_act       = ACT_PUSH;
                    w_push_cand = w_match;
                end else begin
                    w_act = ACT_FLUSH;
                end
            end
            MODE_HASH: begin
                if (r_byte == CH_X_LO || r_byte == CH_X_UP) begin
                    w_act       = ACT_PUSH;
                    w_push_mode = MODE_HEX;
                end else if (w_dig[4]) begin
                    w_act       = w_full ? ACT_FLUSH : ACT_DIGIT;
                    w_push_mode = MODE_DEC;
                end else begin
                    w_act = ACT_FLUSH;
                end
            end
            MODE_DEC, MODE_HEX: begin
                if (w_dig[4]) begin
                    w_act = w_full ? ACT_FLUSH : ACT_DIGIT;
                end else if (r_byte == CH_SEMI && w_stat.has_digits && !w_stat.ovf) begin
                    w_act = ACT_UTF;
                end else begin
                    w_act = ACT_FLUSH;
                end
            end
            default: begin
                w_act = (r_byte == CH_AMP) ? ACT_OPEN : ACT_EMIT_C;
            end
        endcase
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IN: begin
                if (i_in_valid) begin
                    n_state = ST_EVAL;
                end
            end
            ST_EVAL: begin
                unique case (w_act)
                    ACT_EMIT_C, ACT_ENT: begin
                        if (w_ofree) begin
                            n_state = ST_IN;
                        end
                    end
                    ACT_OPEN, ACT_PUSH, ACT_DIGIT: begin
                        n_state = r_last ? ST_AMP : ST_IN;
                    end
                    ACT_UTF: begin
                        n_state = ST_UTF;
                    end
                    default: begin
                        n_state = ST_AMP;
                    end
                endcase
            end
            ST_AMP: begin
                if (w_ofree) begin
                    if (r_count == '0) begin
                        n_state = r_end ? ST_IN : ST_EVAL;
                    end else begin
                        n_state = ST_FBYTE;
                    end
                end
            end
            ST_FBYTE: begin
                if (w_ofree && w_last_idx) begin
                    n_state = r_end ? ST_IN : ST_EVAL;
                end
            end
            ST_UTF: begin
                if (w_ofree && w_utf_last) begin
                    n_state = ST_IN;
                end
            end
            default: begin
                n_state = ST_IN;
            end
        endcase
    end

    // datapath control and emitted byte
    always_comb begin
        n_mode  = r_mode;
        n_count = r_count;
        n_cand  = r_cand;
        n_k     = r_k;
        n_end   = r_end;
        n_byte  = r_byte;
        n_last  = r_last;
        w_emit  = 1'b0;
        w_obyte = r_byte;
        w_final = 1'b0;
        w_we    = 1'b0;
        w_re    = 1'b0;
        w_raddr = '0;
        w_cmd   = '{clr: 1'b0, step: 1'b0, hex: (r_mode == MODE_HEX), digit: w_dig[3:0]};
        unique case (r_state)
            ST_IN: begin
                if (i_in_valid) begin
                    n_byte = i_in_beat.in_byte;
                    n_last = i_in_beat.in_last;
                end
            end
            ST_EVAL: begin
                unique case (w_act)
                    ACT_EMIT_C: begin
                        w_emit  = w_ofree;
                        w_final = 1'b1;
                    end
                    ACT_ENT: begin
                        w_emit  = w_ofree;
                        w_obyte = ent_char(w_done_e);
                        w_final = 1'b1;
                        if (w_ofree) begin
                            n_mode  = MODE_IDLE;
                            n_count = '0;
                        end
                    end
                    ACT_OPEN: begin
                        n_mode    = MODE_NAMED;
                        n_count   = '0;
                        n_cand    = '1;
                        n_end     = 1'b1;
                        w_cmd.clr = 1'b1;
                    end
                    ACT_PUSH: begin
                        w_we    = 1'b1;
                        n_count = r_count + PC_W'(1);
                        n_mode  = w_push_mode;
                        n_cand  = w_push_cand;
                        n_end   = 1'b1;
                    end
                    ACT_DIGIT: begin
                        w_we       = 1'b1;
                        n_count    = r_count + PC_W'(1);
                        n_mode     = w_push_mode;
                        n_end      = 1'b1;
                        w_cmd.step = 1'b1;
                    end
                    ACT_UTF: begin
                        n_k = '0;
                    end
                    default: begin
                        n_end = 1'b0;
                    end
                endcase
            end
            ST_AMP: begin
                w_emit  = w_ofree;
                w_obyte = CH_AMP;
                w_final = (r_count == '0) && w_fin_cond;
                if (w_ofree) begin
                    if (r_count == '0) begin
                        n_mode    = MODE_IDLE;
                        w_cmd.clr = 1'b1;
                    end else begin
                        w_re    = 1'b1;
                        w_raddr = '0;
                        n_k     = '0;
                    end
                end
            end
            ST_FBYTE: begin
                w_emit  = w_ofree;
                w_obyte = w_rdata;
                w_final = w_last_idx && w_fin_cond;
                if (w_ofree) begin
                    if (w_last_idx) begin
                        n_mode    = MODE_IDLE;
                        n_count   = '0;
                        w_cmd.clr = 1'b1;
                    end else begin
                        w_re    = 1'b1;
                        w_raddr = r_k + AW'(1);
                        n_k     = r_k + AW'(1);
                    end
                end
            end
            ST_UTF: begin
                w_emit  = w_ofree;
                w_obyte = utf8_byte(w_stat.value, w_utop, r_k[1:0]);
                w_final = w_utf_last;
                if (w_ofree) begin
                    if (w_utf_last) begin
                        n_mode    = MODE_IDLE;
                        n_count   = '0;
                        w_cmd.clr = 1'b1;
                    end else begin
                        n_k = r_k + AW'(1);
                    end
                end
            end
            default: begin
                n_mode = MODE_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IN;
            r_mode   <= MODE_IDLE;
            r_count  <= '0;
            r_cand   <= '0;
            r_k      <= '0;
            r_end    <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_mode  <= n_mode;
            r_count <= n_count;
            r_cand  <= n_cand;
            r_k     <= n_k;
            r_end   <= n_end;
            if (w_emit) begin
                r_ovalid <= 1'b1;
            end else if (i_out_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_byte <= n_byte;
        r_last <= n_last;
        if (w_emit) begin
            r_obeat <= '{out_byte: w_obyte, run_last: w_final,
                         string_end: (w_final && r_last)};
        end
    end

    assign o_in_ready  = (r_state == ST_IN);
    assign o_out_valid = r_ovalid;
    assign o_out_beat  = r_obeat;

    `XEU_ASSERT_IMP(a_idle_empty, i_clk, i_rst_n, r_mode == MODE_IDLE, r_count == '0, "pending bytes with no open reference")
    `XEU_ASSERT_IMP(a_named_short, i_clk, i_rst_n, r_mode == MODE_NAMED, r_count <= PC_W'(MAX_NAMED_PEND), "named prefix too long")
    `XEU_ASSERT_IMP(a_flush_idx, i_clk, i_rst_n, r_state == ST_FBYTE, PC_W'(r_k) < r_count, "flush index past pending count")
    `XEU_ASSERT_IMP(a_end_run, i_clk, i_rst_n, o_out_valid && o_out_beat.string_end, o_out_beat.run_last, "string end without run end")

endmodule
